// ===== src/pdri_pkg.sv =====
// ----------------------------------------------------------------------------
// pdri_pkg: shared types and constants for the PWM duty rescale interposer
// Operation and register codes, divider sizing and configuration indexes.
// ----------------------------------------------------------------------------
package pdri_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned ProdW     = 2 * DataW;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned DivSteps  = ProdW;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);

  localparam logic [DataW-1:0] FallbackReset = 32'd120000;
  localparam logic [DataW-1:0] HiMask        = 32'hffff0000;
  localparam logic [DataW-1:0] LoMask        = 32'h0000ffff;

  // intercepted operations
  typedef enum logic [1:0] {
    OP_LEGACY_COMBINED = 2'd0,
    OP_LEGACY_CONTROL  = 2'd1,
    OP_FREQUENCY       = 2'd2,
    OP_DUTY            = 2'd3
  } op_e;

  // hardware registers written
  localparam logic [1:0] REG_FREQUENCY = 2'd0;
  localparam logic [1:0] REG_DUTY      = 2'd1;
  localparam logic [1:0] REG_CONTROL   = 2'd2;

  // configuration register indexes
  localparam logic CFG_PRESET   = 1'b0;
  localparam logic CFG_FALLBACK = 1'b1;

endpackage

// ===== src/pdri_div.sv =====
// ----------------------------------------------------------------------------
// pdri_div: bit-serial restoring divider
// Divides a 64-bit dividend by a nonzero 32-bit divisor, one quotient bit per
// cycle; the low 32 quotient bits are returned with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module pdri_div import pdri_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             done_o,
  output logic [DataW-1:0] quotient_o
);

  logic [DataW-1:0]   rem_q;
  logic [ProdW-1:0]   quo_q;
  logic [DataW-1:0]   dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               done_q;

  logic [DataW:0]     rem_shift;
  logic [DataW:0]     rem_sub;
  logic               ge;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_shift = {rem_q, quo_q[ProdW-1]};
    rem_sub   = rem_shift - {1'b0, dvs_q};
    ge        = (rem_shift >= {1'b0, dvs_q});
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DivCntW'(DivSteps);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == DivCntW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - DivCntW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? rem_sub[DataW-1:0] : rem_shift[DataW-1:0];
      quo_q <= {quo_q[ProdW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DataW-1:0];

endmodule

// ===== src/pwm_duty_rescale_interposer_unit.sv =====
// ----------------------------------------------------------------------------
// pwm_duty_rescale_interposer_unit: backlight PWM register-write interposer
// Rewrites intercepted driver writes into one or two hardware writes, with
// duty rescaled to the latched target frequency through a shared divider.
// ----------------------------------------------------------------------------
// Sequence: first result in the cycle after the transfer when no rescale is
//   needed; with a rescale, it follows multiply, load, 64-step divide, capture.
// Throughput: one item at a time; input stalls until the last result is taken,
//   and a rescaling item waits on the bit-serial divider's one bit per cycle.
// Reset: asynchronous active low; clears state, sequencer and registers to
//   preset 0, fallback 120000, latched target, driver frequency and control 0.
module pwm_duty_rescale_interposer_unit import pdri_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DataW-1:0] cfg_data_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       operation_i,
  input  logic [DataW-1:0] write_data_i,
  input  logic [DataW-1:0] readback_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       target_register_o,
  output logic [DataW-1:0] register_value_o,
  output logic             last_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_START = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_EMIT0 = 6'b010000,
    ST_EMIT1 = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [DataW-1:0] preset_q, fallback_q;
  logic [DataW-1:0] target_q, target_d;
  logic [DataW-1:0] driver_q, driver_d;
  logic [DataW-1:0] saved_q, saved_d;

  // result slots
  logic [1:0]       reg0_q, reg0_d, reg1_q, reg1_d;
  logic [DataW-1:0] val0_q, val0_d, val1_q, val1_d;
  logic             two_q, two_d;
  logic             slot_q, slot_d;     // slot receiving the quotient
  logic             need_div;

  // rescale operands
  logic [DataW-1:0] mul_a_q, mul_a_d, mul_b_q, mul_b_d, den_q, den_d;
  logic [ProdW-1:0] prod_q;

  logic             div_done;
  logic [DataW-1:0] div_quo;

  logic             in_xfer;
  logic [DataW-1:0] tgt_latched, tgt_eff;
  logic [DataW-1:0] f_part, d_part;

  assign in_xfer = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q   <= '0;
      fallback_q <= FallbackReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESET:   preset_q   <= cfg_data_i;
        CFG_FALLBACK: fallback_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // decode of an intercepted write
  always_comb begin
    tgt_latched = (target_q != '0) ? target_q :
                  (preset_q != '0) ? preset_q :
                  (readback_i != '0) ? readback_i : fallback_q;
    tgt_eff  = (target_q != '0) ? target_q : preset_q;
    f_part   = (write_data_i & HiMask) >> HalfW;
    d_part   = write_data_i & LoMask;

    target_d = target_q;
    driver_d = driver_q;
    saved_d  = saved_q;
    reg0_d   = REG_FREQUENCY;
    reg1_d   = REG_DUTY;
    val0_d   = '0;
    val1_d   = '0;
    two_d    = 1'b0;
    slot_d   = 1'b0;
    need_div = 1'b0;
    mul_a_d  = write_data_i;
    mul_b_d  = tgt_eff;
    den_d    = driver_q;

    case (op_e'(operation_i))
      OP_LEGACY_COMBINED: begin
        target_d = tgt_latched;
        two_d    = 1'b1;
        reg0_d   = REG_FREQUENCY;
        reg1_d   = REG_DUTY;
        val0_d   = (f_part != '0) ? tgt_latched : '0;
        need_div = (f_part != '0);
        slot_d   = 1'b1;
        mul_a_d  = d_part;
        mul_b_d  = tgt_latched;
        den_d    = f_part;
      end
      OP_LEGACY_CONTROL: begin
        saved_d = (saved_q == '0) ? readback_i : saved_q;
        if (write_data_i != '0) begin
          two_d  = 1'b1;
          reg0_d = REG_FREQUENCY;
          val0_d = tgt_eff;
          reg1_d = REG_CONTROL;
          val1_d = saved_d;
        end else begin
          reg0_d = REG_CONTROL;
          val0_d = '0;
        end
      end
      OP_FREQUENCY: begin
        if (write_data_i != '0) begin
          driver_d = write_data_i;
        end
        target_d = tgt_latched;
        reg0_d   = REG_FREQUENCY;
        val0_d   = (write_data_i != '0) ? tgt_latched : '0;
      end
      OP_DUTY: begin
        reg0_d   = REG_DUTY;
        val0_d   = write_data_i;
        need_div = (driver_q != '0) && (tgt_eff != '0);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_xfer) state_d = need_div ? ST_MUL : ST_EMIT0;
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_EMIT0;
      ST_EMIT0: if (!out_stall_i) state_d = two_q ? ST_EMIT1 : ST_IDLE;
      ST_EMIT1: if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      target_q <= '0;
      driver_q <= '0;
      saved_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        target_q <= target_d;
        driver_q <= driver_d;
        saved_q  <= saved_d;
      end
    end
  end

  // result slots and rescale operands
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      reg0_q  <= reg0_d;
      reg1_q  <= reg1_d;
      val0_q  <= val0_d;
      val1_q  <= val1_d;
      two_q   <= two_d;
      slot_q  <= slot_d;
      mul_a_q <= mul_a_d;
      mul_b_q <= mul_b_d;
      den_q   <= den_d;
    end else if (state_q == ST_DIV && div_done) begin
      if (slot_q) val1_q <= div_quo;
      else        val0_q <= div_quo;
    end
    if (state_q == ST_MUL) begin
      prod_q <= ProdW'(mul_a_q) * ProdW'(mul_b_q);
    end
  end

  pdri_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_START),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // output channel
  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = (state_q == ST_EMIT0) || (state_q == ST_EMIT1);
  assign target_register_o = (state_q == ST_EMIT1) ? reg1_q : reg0_q;
  assign register_value_o  = (state_q == ST_EMIT1) ? val1_q : val0_q;
  assign last_o            = (state_q == ST_EMIT1) || !two_q;

endmodule

// ===== src/pdri_checker.sv =====
// ----------------------------------------------------------------------------
// pdri_checker: port-level assertions for the interposer
// Watches the handshakes and result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module pdri_checker import pdri_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       target_register_o,
  input logic [DataW-1:0] register_value_o,
  input logic             last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(register_value_o)
      && $stable(target_register_o) && $stable(last_o))
    else $error("stalled result changed");

  // busy right after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while item in flight");

  // no input taken while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input ready with result pending");

  // second result follows a non-final transfer at once
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && last_o)
    else $error("second result missing");

endmodule

bind pwm_duty_rescale_interposer_unit pdri_checker u_pdri_checker (.*);
